/* hdl/pbse_pkg.sv */
// pbse_pkg: shared types and constants of the run-length segment encoder
// used by the channel interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package pbse_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 3;
  localparam int LANES   = 4;

  localparam logic [CNT_W-1:0] FILL_FULL = 3'd4;
  localparam logic [8:0]       RUN_BASE  = 9'd257;
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PUSH2,
    ST_LIT_CHECK,
    ST_LIT_HDR,
    ST_LIT_DATA,
    ST_RUN_CHECK,
    ST_RUN_HDR,
    ST_RUN_BYTE,
    ST_PAD_CHECK,
    ST_PAD,
    ST_FINISH
  } state_t;

  // what the current item is doing
  typedef enum logic [1:0] {
    CTX_EXTEND,
    CTX_NEWBYTE,
    CTX_FLUSH
  } ctx_t;

  // source of the byte sent to the packer
  typedef enum logic [2:0] {
    SEL_LIT_HDR,
    SEL_LIT_DATA,
    SEL_RUN_HDR,
    SEL_RUN_BYTE,
    SEL_PAD
  } sel_t;

  typedef struct packed {
    logic take;
    logic run_inc;
    logic run_clear;
    logic run_sub;
    logic set_run;
    logic seg_clear;
    logic push_prev;
    logic pkt_start;
    logic lit_pop;
    logic byte_push;
    sel_t sel;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic mode;
    logic match;
    logic prev_valid;
    logic run_zero;
    logic run_is1;
    logic run_is2;
    logic run_ge2;
    logic run_ge_max;
    logic lit_zero;
    logic lit_gt_max;
    logic pkt_last;
    logic parity;
    logic byte_ready;
    logic fin_ready;
    logic buf_empty;
  } stat_t;

endpackage

/* hdl/pbse_byte_if.sv */
// pbse_byte_if: input channel of the encoder, one data byte or end-of-segment mark per beat
// depends on pbse_pkg for field widths
`timescale 1ns / 1ps

interface pbse_byte_if import pbse_pkg::*;;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);

endinterface

/* hdl/pbse_word_if.sv */
// pbse_word_if: output channel of the encoder, up to four encoded bytes per beat
// depends on pbse_pkg for field widths
`timescale 1ns / 1ps

interface pbse_word_if import pbse_pkg::*;;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic [CNT_W-1:0]  byte_count;
  logic              last;

  modport source (output valid, output out_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input out_word, input byte_count, input last,
                  output ready);

endinterface

/* hdl/pbse_ctrl.sv */
// pbse_ctrl: sequencing state machine of the encoder
// depends on pbse_pkg; drives datapath commands from datapath status
`timescale 1ns / 1ps

module pbse_ctrl import pbse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  ctx_t   ctx, ctx_next;

  // state and context registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctx   <= CTX_EXTEND;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    cmd        = '0;
    cmd.sel    = SEL_PAD;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.mode == MODE_FLUSH) begin
          // single leftover byte joins the literals, a pair stays a run
          ctx_next = CTX_FLUSH;
          if (!stat.run_ge2) cmd.run_clear = 1'b1;
          if (stat.prev_valid && stat.run_is1) cmd.push_prev = 1'b1;
          state_next = ST_LIT_CHECK;
        end else if (stat.match) begin
          ctx_next    = CTX_EXTEND;
          cmd.run_inc = 1'b1;
          if (stat.run_ge2 && !stat.lit_zero) state_next = ST_LIT_CHECK;
          else if (stat.run_ge_max)           state_next = ST_RUN_HDR;
          else                                state_next = ST_FINISH;
        end else begin
          ctx_next = CTX_NEWBYTE;
          if (!stat.prev_valid) begin
            cmd.set_run = 1'b1;
            state_next  = ST_FINISH;
          end else if (stat.run_is1) begin
            cmd.push_prev = 1'b1;
            state_next    = ST_LIT_CHECK;
          end else if (stat.run_is2) begin
            cmd.push_prev = 1'b1;
            state_next    = ST_PUSH2;
          end else begin
            state_next = ST_RUN_CHECK;
          end
        end
      end
      ST_PUSH2: begin
        cmd.push_prev = 1'b1;
        state_next    = ST_LIT_CHECK;
      end
      ST_LIT_CHECK: begin
        // new byte sends only an overflow packet, the others drain everything
        if ((ctx == CTX_NEWBYTE) ? stat.lit_gt_max : !stat.lit_zero) begin
          cmd.pkt_start = 1'b1;
          state_next    = ST_LIT_HDR;
        end else begin
          case (ctx)
            CTX_NEWBYTE: begin
              cmd.set_run = 1'b1;
              state_next  = ST_FINISH;
            end
            CTX_FLUSH: state_next = ST_RUN_CHECK;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_LIT_HDR: begin
        cmd.sel = SEL_LIT_HDR;
        if (stat.byte_ready) begin
          cmd.byte_push = 1'b1;
          state_next    = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        cmd.sel = SEL_LIT_DATA;
        if (stat.byte_ready) begin
          cmd.byte_push = 1'b1;
          cmd.lit_pop   = 1'b1;
          if (stat.pkt_last) state_next = ST_LIT_CHECK;
        end
      end
      ST_RUN_CHECK: begin
        if (!stat.run_zero) begin
          state_next = ST_RUN_HDR;
        end else if (ctx == CTX_FLUSH) begin
          state_next = ST_PAD_CHECK;
        end else begin
          cmd.set_run = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      ST_RUN_HDR: begin
        cmd.sel = SEL_RUN_HDR;
        if (stat.byte_ready) begin
          cmd.byte_push = 1'b1;
          state_next    = ST_RUN_BYTE;
        end
      end
      ST_RUN_BYTE: begin
        cmd.sel = SEL_RUN_BYTE;
        if (stat.byte_ready) begin
          cmd.byte_push = 1'b1;
          cmd.run_sub   = 1'b1;
          state_next    = (ctx == CTX_EXTEND) ? ST_FINISH : ST_RUN_CHECK;
        end
      end
      ST_PAD_CHECK: begin
        // segment done, pad to an even length
        cmd.seg_clear = 1'b1;
        state_next    = stat.parity ? ST_PAD : ST_FINISH;
      end
      ST_PAD: begin
        cmd.sel = SEL_PAD;
        if (stat.byte_ready) begin
          cmd.byte_push = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.fin_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/pbse_dp.sv */
// pbse_dp: datapath of the encoder: run state, literal memory, byte packer, output register
// depends on pbse_pkg, pbse_byte_if and pbse_word_if; steered by pbse_ctrl
`timescale 1ns / 1ps

module pbse_dp import pbse_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  logic        clk,
  input  logic        rst,
  pbse_byte_if.sink   byte_ch,
  pbse_word_if.source word_ch,
  input  cmd_t        cmd,
  output stat_t       stat
);

  // counts reach a packet plus a folded pair
  localparam int CW    = $clog2(MAX_PACKET + 3);
  localparam int AW    = $clog2(MAX_PACKET + 2);
  localparam int DEPTH = 1 << AW;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  logic              cur_mode;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] prev_byte;
  logic              prev_valid;
  logic [CW-1:0]     run_count;
  logic [CW-1:0]     lit_count;
  logic [CW-1:0]     pkt_left;
  logic [AW-1:0]     head, head_next, tail;
  logic              parity;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic [WORD_W-1:0] buf_word;
  logic [CNT_W-1:0]  fill;
  logic              o_valid;
  logic [WORD_W-1:0] o_word;
  logic [CNT_W-1:0]  o_count;
  logic              o_last;

  logic              accept;
  logic              out_free;
  logic              load_full;
  logic              load_fin;
  logic [CW-1:0]     n_run;
  logic [CW-1:0]     n_lit;
  logic [BYTE_W-1:0] byte_val;

  assign accept    = cmd.take && byte_ch.valid;
  assign head_next = cmd.lit_pop ? head + 1'b1 : head;
  assign n_run     = (run_count > MAX_C) ? MAX_C : run_count;
  assign n_lit     = (lit_count > MAX_C) ? MAX_C : lit_count;
  assign out_free  = !o_valid || word_ch.ready;
  assign load_full = cmd.byte_push && (fill == FILL_FULL);
  assign load_fin  = cmd.finish && (fill != '0);

  // byte going to the packer
  always_comb begin
    unique case (cmd.sel)
      SEL_LIT_HDR:  byte_val = BYTE_W'(pkt_left - ONE_C);
      SEL_LIT_DATA: byte_val = rd_data;
      SEL_RUN_HDR:  byte_val = BYTE_W'(RUN_BASE - 9'(n_run));
      SEL_RUN_BYTE: byte_val = prev_byte;
      SEL_PAD:      byte_val = PAD_BYTE;
      default:      byte_val = PAD_BYTE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte  <= '0;
      prev_valid <= 1'b0;
      run_count  <= '0;
      lit_count  <= '0;
      pkt_left   <= '0;
      head       <= '0;
      tail       <= '0;
      parity     <= 1'b0;
      fill       <= '0;
      o_valid    <= 1'b0;
    end else begin
      // open run
      if (cmd.set_run) begin
        prev_byte  <= cur_byte;
        prev_valid <= 1'b1;
        run_count  <= ONE_C;
      end else if (cmd.seg_clear) begin
        prev_byte  <= '0;
        prev_valid <= 1'b0;
        run_count  <= '0;
      end else if (cmd.run_inc) begin
        run_count <= run_count + ONE_C;
      end else if (cmd.run_clear) begin
        run_count <= '0;
      end else if (cmd.run_sub) begin
        run_count <= run_count - n_run;
      end

      // literal queue pointers
      if (cmd.push_prev) begin
        lit_count <= lit_count + ONE_C;
        tail      <= tail + 1'b1;
      end else if (cmd.lit_pop) begin
        lit_count <= lit_count - ONE_C;
      end else if (cmd.seg_clear) begin
        lit_count <= '0;
      end
      head <= head_next;

      // bytes left in the current literal packet
      if (cmd.pkt_start)    pkt_left <= n_lit;
      else if (cmd.lit_pop) pkt_left <= pkt_left - ONE_C;

      if (cmd.byte_push) parity <= ~parity;

      // packer fill level
      if (cmd.byte_push) begin
        if (fill == FILL_FULL) fill <= CNT_W'(1);
        else                   fill <= fill + 1'b1;
      end else if (load_fin) begin
        fill <= '0;
      end

      // output register handshake
      if (load_full || load_fin) o_valid <= 1'b1;
      else if (word_ch.ready)    o_valid <= 1'b0;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode <= byte_ch.mode;
      cur_byte <= byte_ch.data_byte;
    end
  end

  // literal memory, read address follows the head
  always_ff @(posedge clk) begin
    if (cmd.push_prev) mem[tail] <= prev_byte;
    rd_data <= mem[head_next];
  end

  // packer word and output payload
  always_ff @(posedge clk) begin
    if (cmd.byte_push) begin
      if (fill == '0 || fill == FILL_FULL) begin
        buf_word <= WORD_W'(byte_val);
      end else begin
        for (int i = 1; i < LANES; i++) begin
          if (fill[1:0] == 2'(i)) buf_word[i*BYTE_W +: BYTE_W] <= byte_val;
        end
      end
    end
    if (load_full) begin
      o_word  <= buf_word;
      o_count <= FILL_FULL;
      o_last  <= 1'b0;
    end else if (load_fin) begin
      o_word  <= buf_word;
      o_count <= fill;
      o_last  <= 1'b1;
    end
  end

  assign byte_ch.ready      = cmd.take;
  assign word_ch.valid      = o_valid;
  assign word_ch.out_word   = o_word;
  assign word_ch.byte_count = o_count;
  assign word_ch.last       = o_last;

  // status to the controller
  always_comb begin
    stat.in_valid   = byte_ch.valid;
    stat.mode       = cur_mode;
    stat.match      = prev_valid && (cur_byte == prev_byte);
    stat.prev_valid = prev_valid;
    stat.run_zero   = (run_count == '0);
    stat.run_is1    = (run_count == ONE_C);
    stat.run_is2    = (run_count == TWO_C);
    stat.run_ge2    = (run_count >= TWO_C);
    stat.run_ge_max = (run_count >= MAX_C);
    stat.lit_zero   = (lit_count == '0);
    stat.lit_gt_max = (lit_count > MAX_C);
    stat.pkt_last   = (pkt_left == ONE_C);
    stat.parity     = parity;
    stat.byte_ready = (fill != FILL_FULL) || out_free;
    stat.fin_ready  = (fill == '0) || out_free;
    stat.buf_empty  = (fill == '0);
  end

endmodule

/* hdl/packbits_segment_encoder.sv */
// packbits_segment_encoder: top level of the run-length segment encoder
// depends on pbse_pkg, pbse_byte_if, pbse_word_if, pbse_ctrl and pbse_dp
//
// Usage:
//   byte_ch carries one item per beat: mode 0 with a data byte of the segment,
//   or mode 1 to end the segment (flush pending bytes, pad to even length).
//   word_ch carries the encoded stream, up to four bytes per beat, first byte
//   in bits 7:0, byte_count valid bytes, last set on the final word of an item.
//   An item that encodes to nothing gives no word.
// Sequencing:
//   One item at a time: the input is ready again only once the item is done;
//   it takes longer for each encoded byte, each literal or run packet drained
//   plus a closing check, a folded pair and the pad check at end of segment.
//   A third equal byte that drains a full 128-byte literal packet holds the
//   input until that packet is sent; word_ch stalls add to this.
// Reset and stalls:
//   rst (synchronous) empties the run state, the literal queue and the output
//   register. When word_ch stalls, the packer holds a full word and the
//   sequencer waits; the next item is still taken while the last word waits.
`timescale 1ns / 1ps

module packbits_segment_encoder import pbse_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input logic         clk,
  input logic         rst,
  pbse_byte_if.sink   byte_ch,
  pbse_word_if.source word_ch
);

  cmd_t  cmd;
  stat_t stat;

  pbse_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pbse_dp #(
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .word_ch (word_ch),
    .cmd     (cmd),
    .stat    (stat)
  );

  // between items the packer is empty and the literal queue fits one packet
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    byte_ch.ready |-> (stat.buf_empty && !stat.lit_gt_max))
    else $error("encoder idle with bytes pending in packer or queue");

  // a byte only enters the packer when it has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_push |-> stat.byte_ready)
    else $error("byte pushed into a full packer");

  // a literal is only taken from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.lit_pop |-> !stat.lit_zero)
    else $error("literal read from an empty queue");

  // an accepted beat keeps the input closed for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && byte_ch.ready) |=> !byte_ch.ready)
    else $error("input taken again before the item was processed");

endmodule
